// File: design/bfi_pkg.sv
// Shared constants, character codes and controller/datapath interface types.
`default_nettype none

package bfi_pkg;

    localparam int TAPE_DEPTH    = 32768;
    localparam int PROGRAM_DEPTH = 4096;

    localparam int TAPE_AW = $clog2(TAPE_DEPTH);
    localparam int PROG_AW = $clog2(PROGRAM_DEPTH);
    localparam int LEN_W   = $clog2(PROGRAM_DEPTH + 1);

    localparam logic [1:0] STAT_RUN       = 2'd0;
    localparam logic [1:0] STAT_WAIT      = 2'd1;
    localparam logic [1:0] STAT_DONE      = 2'd2;
    localparam logic [1:0] STAT_UNMATCHED = 2'd3;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;

    // controller -> datapath: operation for this cycle
    typedef struct packed {
        logic clear;
        logic accept;
        logic decode;
        logic fwd;
        logic bwd;
        logic cmt;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic go_fetch;
        logic go_fwd;
        logic go_bwd;
        logic go_cmt;
        logic scan_end;
    } sts_t;

endpackage

`default_nettype wire

// File: design/brainfuck_interpreter_core.sv
// Top level of the interpreter core: controller plus datapath.
//
// After reset the core clears all TAPE_DEPTH (32768) tape cells, one cell per
// cycle with busy high, before it takes its first item. An item transfers on
// a clock edge with start high and busy low. A load answers in the cycle after
// the transfer. An execute reads program and tape memories at the transfer
// edge, then decodes and writes the tape in the fetch state and registers its
// result; an execute past the end of the program answers like a load. A
// bracket or comment at that position then scans the program one byte at a
// time through the single read port of the program memory; a forward bracket
// scan or a comment scan runs off the end of the program only after it has
// stepped past the last byte. Each result is on done, out_valid, out_byte and
// status for exactly one cycle and cannot be held off; busy is already low in
// that cycle, so the next item may transfer with it.
`default_nettype none

module brainfuck_interpreter_core
    import bfi_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    output logic       busy,
    input  wire        kind,
    input  wire  [7:0] prog_byte,
    input  wire        prog_last,
    input  wire        in_valid,
    input  wire  [7:0] in_byte,
    input  wire        in_eof,
    output logic       done,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic [1:0] status
);

    cmd_t cmd;
    sts_t sts;

    bfi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    bfi_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .kind      (kind),
        .prog_byte (prog_byte),
        .prog_last (prog_last),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .in_eof    (in_eof),
        .done      (done),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .status    (status)
    );

endmodule

`default_nettype wire

// File: design/bfi_ctrl.sv
// Sequencing state machine: tape clear, idle, fetch/decode and program scans.
`default_nettype none

module bfi_ctrl
    import bfi_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  start,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_FETCH = 6'b000100,
        S_FWD   = 6'b001000,
        S_BWD   = 6'b010000,
        S_CMT   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (sts.go_fetch)
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                cmd.decode = 1'b1;
                if (sts.go_fwd)
                begin
                    state_next = S_FWD;
                end
                else if (sts.go_bwd)
                begin
                    state_next = S_BWD;
                end
                else if (sts.go_cmt)
                begin
                    state_next = S_CMT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FWD:
            begin
                cmd.fwd = 1'b1;
                if (sts.scan_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_BWD:
            begin
                cmd.bwd = 1'b1;
                if (sts.scan_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CMT:
            begin
                cmd.cmt = 1'b1;
                if (sts.scan_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// File: design/bfi_dpath.sv
// Datapath: program and tape memories, pointers, scan counter and result registers.
`default_nettype none

module bfi_dpath
    import bfi_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  cmd_t       cmd,
    output sts_t       sts,
    input  wire        kind,
    input  wire  [7:0] prog_byte,
    input  wire        prog_last,
    input  wire        in_valid,
    input  wire  [7:0] in_byte,
    input  wire        in_eof,
    output logic       done,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic [1:0] status
);

    logic [7:0] tape_mem [TAPE_DEPTH];
    logic [7:0] prog_mem [PROGRAM_DEPTH];

    logic [7:0] tape_rdata_reg;
    logic [7:0] prog_rdata_reg;

    logic [LEN_W-1:0]   plen_reg,  plen_next;
    logic [LEN_W-1:0]   pc_reg,    pc_next;
    logic [TAPE_AW-1:0] cp_reg,    cp_next;
    logic [LEN_W-1:0]   depth_reg, depth_next;
    logic [LEN_W-1:0]   idx_reg,   idx_next;
    logic [TAPE_AW-1:0] clr_reg,   clr_next;
    logic               closed_reg, closed_next;
    logic               done_reg,  done_next;
    logic               oval_reg,  oval_next;
    logic [7:0]         obyte_reg, obyte_next;
    logic [1:0]         stat_reg,  stat_next;
    logic               ival_reg,  ival_next;
    logic [7:0]         ibyte_reg, ibyte_next;
    logic               ieof_reg,  ieof_next;

    logic               tape_we;
    logic [TAPE_AW-1:0] tape_waddr;
    logic [7:0]         tape_wdata;
    logic               prog_we;
    logic [PROG_AW-1:0] prog_waddr;
    logic [PROG_AW-1:0] prog_raddr;

    logic               respond;
    logic               resp_valid;
    logic [1:0]         resp_stat;
    logic [LEN_W-1:0]   base_len;
    logic [LEN_W-1:0]   pc_inc;
    logic [LEN_W-1:0]   pc_dec;
    logic [LEN_W-1:0]   idx_inc;
    logic [LEN_W-1:0]   idx_dec;
    logic [LEN_W-1:0]   depth_inc;
    logic [LEN_W-1:0]   depth_dec;
    logic               is_blank;

    assign pc_inc    = pc_reg + 1'b1;
    assign pc_dec    = pc_reg - 1'b1;
    assign idx_inc   = idx_reg + 1'b1;
    assign idx_dec   = idx_reg - 1'b1;
    assign depth_inc = depth_reg + 1'b1;
    assign depth_dec = depth_reg - 1'b1;
    assign base_len  = closed_reg ? '0 : plen_reg;
    assign is_blank  = (prog_rdata_reg == CH_SP) || (prog_rdata_reg == CH_TAB)
                    || (prog_rdata_reg == CH_NL) || (prog_rdata_reg == CH_VT)
                    || (prog_rdata_reg == CH_FF) || (prog_rdata_reg == CH_CR);

    always_ff @(posedge clk)
    begin
        if (tape_we)
        begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        tape_rdata_reg <= tape_mem[cp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (prog_we)
        begin
            prog_mem[prog_waddr] <= prog_byte;
        end
        prog_rdata_reg <= prog_mem[prog_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg   <= '0;
            pc_reg     <= '0;
            cp_reg     <= '0;
            depth_reg  <= '0;
            idx_reg    <= '0;
            clr_reg    <= '0;
            closed_reg <= 1'b0;
            done_reg   <= 1'b0;
            oval_reg   <= 1'b0;
            obyte_reg  <= '0;
            stat_reg   <= STAT_RUN;
        end
        else
        begin
            plen_reg   <= plen_next;
            pc_reg     <= pc_next;
            cp_reg     <= cp_next;
            depth_reg  <= depth_next;
            idx_reg    <= idx_next;
            clr_reg    <= clr_next;
            closed_reg <= closed_next;
            done_reg   <= done_next;
            oval_reg   <= oval_next;
            obyte_reg  <= obyte_next;
            stat_reg   <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ival_reg  <= ival_next;
        ibyte_reg <= ibyte_next;
        ieof_reg  <= ieof_next;
    end

    always_comb
    begin
        plen_next   = plen_reg;
        pc_next     = pc_reg;
        cp_next     = cp_reg;
        depth_next  = depth_reg;
        idx_next    = idx_reg;
        clr_next    = clr_reg;
        closed_next = closed_reg;
        ival_next   = ival_reg;
        ibyte_next  = ibyte_reg;
        ieof_next   = ieof_reg;
        tape_we     = 1'b0;
        tape_waddr  = cp_reg;
        tape_wdata  = '0;
        prog_we     = 1'b0;
        prog_waddr  = base_len[PROG_AW-1:0];
        prog_raddr  = pc_reg[PROG_AW-1:0];
        respond     = 1'b0;
        resp_valid  = 1'b0;
        resp_stat   = STAT_RUN;
        sts         = '0;

        if (cmd.clear)
        begin
            tape_we      = 1'b1;
            tape_waddr   = clr_reg;
            clr_next     = clr_reg + 1'b1;
            sts.clr_last = (clr_reg == TAPE_AW'(TAPE_DEPTH - 1));
        end
        else if (cmd.accept)
        begin
            ival_next  = in_valid;
            ibyte_next = in_byte;
            ieof_next  = in_eof;
            if (!kind)
            begin
                respond     = 1'b1;
                closed_next = prog_last;
                if (closed_reg)
                begin
                    pc_next = '0;
                end
                if (base_len < LEN_W'(PROGRAM_DEPTH))
                begin
                    prog_we   = 1'b1;
                    plen_next = base_len + 1'b1;
                end
                else
                begin
                    plen_next = base_len;
                end
            end
            else if (pc_reg < plen_reg)
            begin
                sts.go_fetch = 1'b1;
            end
            else
            begin
                respond   = 1'b1;
                resp_stat = STAT_DONE;
            end
        end
        else if (cmd.decode)
        begin
            respond = 1'b1;
            pc_next = pc_inc;
            if (!is_blank)
            begin
                case (prog_rdata_reg)
                    CH_HASH:
                    begin
                        respond    = 1'b0;
                        pc_next    = pc_reg;
                        sts.go_cmt = 1'b1;
                        idx_next   = pc_inc;
                        prog_raddr = pc_inc[PROG_AW-1:0];
                    end
                    CH_GT:
                    begin
                        cp_next = (cp_reg == TAPE_AW'(TAPE_DEPTH - 1)) ? '0 : cp_reg + 1'b1;
                    end
                    CH_LT:
                    begin
                        cp_next = (cp_reg == '0) ? TAPE_AW'(TAPE_DEPTH - 1) : cp_reg - 1'b1;
                    end
                    CH_PLUS:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = tape_rdata_reg + 8'd1;
                    end
                    CH_MINUS:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = tape_rdata_reg - 8'd1;
                    end
                    CH_DOT:
                    begin
                        resp_valid = 1'b1;
                    end
                    CH_COMMA:
                    begin
                        if (ieof_reg)
                        begin
                            tape_we    = 1'b1;
                            tape_wdata = 8'hFF;
                        end
                        else if (ival_reg)
                        begin
                            tape_we    = 1'b1;
                            tape_wdata = ibyte_reg;
                        end
                        else
                        begin
                            pc_next   = pc_reg;
                            resp_stat = STAT_WAIT;
                        end
                    end
                    CH_LBRK:
                    begin
                        if (tape_rdata_reg == 8'd0)
                        begin
                            respond    = 1'b0;
                            pc_next    = pc_reg;
                            depth_next = LEN_W'(1);
                            idx_next   = pc_inc;
                            prog_raddr = pc_inc[PROG_AW-1:0];
                            sts.go_fwd = 1'b1;
                        end
                    end
                    CH_RBRK:
                    begin
                        if (tape_rdata_reg != 8'd0)
                        begin
                            pc_next = pc_reg;
                            if (pc_reg == '0)
                            begin
                                resp_stat = STAT_UNMATCHED;
                            end
                            else
                            begin
                                respond    = 1'b0;
                                depth_next = LEN_W'(1);
                                idx_next   = pc_dec;
                                prog_raddr = pc_dec[PROG_AW-1:0];
                                sts.go_bwd = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (cmd.fwd)
        begin
            if (idx_reg >= plen_reg)
            begin
                respond      = 1'b1;
                resp_stat    = STAT_UNMATCHED;
                depth_next   = '0;
                sts.scan_end = 1'b1;
            end
            else
            begin
                if (prog_rdata_reg == CH_LBRK)
                begin
                    depth_next = depth_inc;
                end
                else if (prog_rdata_reg == CH_RBRK)
                begin
                    depth_next = depth_dec;
                end
                if ((prog_rdata_reg == CH_RBRK) && (depth_dec == '0))
                begin
                    respond      = 1'b1;
                    pc_next      = idx_inc;
                    sts.scan_end = 1'b1;
                end
                else
                begin
                    idx_next   = idx_inc;
                    prog_raddr = idx_inc[PROG_AW-1:0];
                end
            end
        end
        else if (cmd.bwd)
        begin
            if (prog_rdata_reg == CH_RBRK)
            begin
                depth_next = depth_inc;
            end
            else if (prog_rdata_reg == CH_LBRK)
            begin
                depth_next = depth_dec;
            end
            if ((prog_rdata_reg == CH_LBRK) && (depth_dec == '0))
            begin
                respond      = 1'b1;
                pc_next      = idx_inc;
                sts.scan_end = 1'b1;
            end
            else if (idx_reg == '0)
            begin
                respond      = 1'b1;
                resp_stat    = STAT_UNMATCHED;
                depth_next   = '0;
                sts.scan_end = 1'b1;
            end
            else
            begin
                idx_next   = idx_dec;
                prog_raddr = idx_dec[PROG_AW-1:0];
            end
        end
        else if (cmd.cmt)
        begin
            if (idx_reg >= plen_reg)
            begin
                respond      = 1'b1;
                pc_next      = plen_reg;
                sts.scan_end = 1'b1;
            end
            else if ((prog_rdata_reg == CH_NL) || (prog_rdata_reg == CH_NUL))
            begin
                respond      = 1'b1;
                pc_next      = idx_inc;
                sts.scan_end = 1'b1;
            end
            else
            begin
                idx_next   = idx_inc;
                prog_raddr = idx_inc[PROG_AW-1:0];
            end
        end
    end

    assign done_next  = respond;
    assign oval_next  = respond & resp_valid;
    assign obyte_next = (respond & resp_valid) ? tape_rdata_reg : 8'd0;
    assign stat_next  = respond ? resp_stat : STAT_RUN;

    assign done      = done_reg;
    assign out_valid = oval_reg;
    assign out_byte  = obyte_reg;
    assign status    = stat_reg;

endmodule

`default_nettype wire

// File: design/bfi_checker.sv
// Port-level checks on the interpreter core, bound to the top level.
`default_nettype none

module bfi_checker
    import bfi_pkg::*;
(
    input wire       clk,
    input wire       rst_n,
    input wire       start,
    input wire       busy,
    input wire       kind,
    input wire       done,
    input wire       out_valid,
    input wire [7:0] out_byte,
    input wire [1:0] status
);

    a_load_answers: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !kind |=> done && !out_valid && (status == STAT_RUN))
        else $error("load transfer not answered in the next cycle");

    a_exec_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && kind |=> busy || done)
        else $error("execute transfer neither busy nor answered");

    a_out_with_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> done && (status == STAT_RUN))
        else $error("output byte without strobe or with error status");

    a_quiet_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (out_byte == 8'd0) && (status == STAT_RUN))
        else $error("result ports not quiet between strobes");

endmodule

bind brainfuck_interpreter_core bfi_checker u_bfi_checker (.*);

`default_nettype wire
